### sv/spectrum_smooth_colorize_top_assert.svh
// Assertion macros used by the spectrum smoothing and colour mapping RTL.
`ifndef SPECTRUM_SMOOTH_COLORIZE_TOP_ASSERT_SVH
`define SPECTRUM_SMOOTH_COLORIZE_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define SSC_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SSC_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ssc_pkg.sv
// Package with constants, register codes and the colour table of the spectrum colorizer.
package ssc_pkg;

	localparam int BIN_COUNT_DEF = 1024;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEGATE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CEIL   = 3'd4;

	localparam logic [16:0] WEIGHT_RST = 17'd6554;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;
	localparam logic signed [16:0] FLOOR_RST = -17'sd25600;
	localparam logic signed [15:0] CEIL_RST  = 16'sd0;

	// -1000 dB in Q12.8
	localparam logic signed [19:0] AVG_RESET = -20'sd256000;

	localparam int DIV_STEPS = 20;
	localparam logic [19:0] ID_SCALE  = 20'd999999;
	localparam logic [23:0] MAP_STEPS = 24'd1000000;
	localparam logic [29:0] MAP_STEPS_W = 30'd1000000;
	localparam logic [3:0]  COLOUR_LAST = 4'd12;
	localparam logic [3:0]  COLOUR_MUL  = 4'd13;
	// ceil(2^40 / 10^6) for the reciprocal divide
	localparam logic [20:0] RECIP_M  = 21'd1099512;
	localparam logic signed [29:0] U_OFFSET = 30'sd255000000;

	localparam logic [23:0] COLOUR_ZERO = 24'h000020;

	typedef logic [23:0] rgb_t;  // {red, green, blue}

	function automatic rgb_t colour_rgb(input logic [3:0] idx);
		rgb_t c;
		case (idx)
			4'd0:    c = 24'h000020;
			4'd1:    c = 24'h000030;
			4'd2:    c = 24'h000050;
			4'd3:    c = 24'h000091;
			4'd4:    c = 24'h1E90FF;
			4'd5:    c = 24'hFFFFFF;
			4'd6:    c = 24'hFFFF00;
			4'd7:    c = 24'hFE6D16;
			4'd8:    c = 24'hFF0000;
			4'd9:    c = 24'hC60000;
			4'd10:   c = 24'h9F0000;
			4'd11:   c = 24'h750000;
			4'd12:   c = 24'h4A0000;
			default: c = 24'h000020;
		endcase
		return c;
	endfunction

endpackage

### sv/spectrum_smooth_colorize_top.sv
// Spectrum bin smoothing with per-bin exponential average and 13-colour waterfall map.
// One item per clock when the output is not stalled, once the reset sweep is over. After reset the
// per-bin average store (BIN_COUNT entries) is swept to -1000 dB, one entry per cycle, and
// s_tready stays low until the sweep ends; configuration writes are taken during the sweep.
// The whole pipeline advances on one enable: it moves whenever the output register is
// empty or being drained. Smoothing reads the store when an item is taken and writes the
// blended value back one stage later; a back-to-back item on the same bin picks the fresh
// value off the pipeline instead of the store. The colour index needs (x-floor)*999999/span,
// done by a 20-stage restoring divider, one quotient bit per stage; the final blend between
// neighbouring colours divides by 10^6 through a reciprocal multiply with one correction.
// Configuration must be written only while the block is idle.
`include "spectrum_smooth_colorize_top_assert.svh"

module spectrum_smooth_colorize_top
	import ssc_pkg::*;
#(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] bin_index, [26:10] power_db, rest zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] bin_number, [28:10] level_db,
	                                          // [36:29] red, [44:37] green, [52:45] blue
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ADDR_W = $clog2(BIN_COUNT);

	// Configuration registers
	logic [16:0]        weight_q;
	logic               smooth_q;
	logic               negate_q;
	logic signed [16:0] floor_q;
	logic signed [15:0] ceil_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RST;
			smooth_q <= 1'b1;
			negate_q <= 1'b0;
			floor_q  <= FLOOR_RST;
			ceil_q   <= CEIL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WEIGHT: weight_q <= cfg_data;
				CFG_SMOOTH: smooth_q <= cfg_data[0];
				CFG_NEGATE: negate_q <= cfg_data[0];
				CFG_FLOOR:  floor_q  <= $signed(cfg_data);
				CFG_CEIL:   ceil_q   <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// Store clear sweep after reset
	logic [ADDR_W-1:0] clr_q;
	logic              clr_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ADDR_W'(BIN_COUNT - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// Global advance: the output register is free or drains this cycle
	logic adv;
	logic v_s9;
	assign adv      = !v_s9 || m_tready;
	assign s_tready = adv && clr_done_q;

	logic               take;
	logic [9:0]         in_bin;
	logic signed [16:0] in_pwr;
	assign take   = s_tvalid && s_tready;
	assign in_bin = s_tdata[9:0];
	assign in_pwr = $signed(s_tdata[26:10]);

	// Stage 1: item with store read data
	logic               v_s1;
	logic [9:0]         bin_s1;
	logic signed [16:0] pwr_s1;
	logic               inr_s1;
	logic               fwd_s1;
	logic signed [19:0] rd_q;

	// Blend
	logic signed [19:0] avg_s2;
	logic signed [19:0] avg_w;
	logic [16:0]        a_w;
	logic signed [20:0] diff_w;
	logic signed [38:0] prod_w;
	logic signed [38:0] rnd_w;
	logic signed [22:0] sum_w;
	logic signed [19:0] blend_w;
	logic               use_sm;
	logic signed [19:0] lvl0_w;
	logic signed [20:0] lvl_w;

	assign avg_w   = fwd_s1 ? avg_s2 : rd_q;
	assign a_w     = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign diff_w  = {{4{pwr_s1[16]}}, pwr_s1} - {avg_w[19], avg_w};
	assign prod_w  = $signed({1'b0, a_w}) * diff_w;
	assign rnd_w   = prod_w + 39'sd32768;
	assign sum_w   = {{3{avg_w[19]}}, avg_w} + rnd_w[38:16];
	assign blend_w = sum_w[19:0];
	assign use_sm  = smooth_q && inr_s1;
	assign lvl0_w  = use_sm ? blend_w : {{3{pwr_s1[16]}}, pwr_s1};
	assign lvl_w   = negate_q ? -{lvl0_w[19], lvl0_w} : {lvl0_w[19], lvl0_w};

	// Store: one write port (sweep or write-back), one registered read port
	logic signed [19:0] avg_mem [BIN_COUNT];
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic signed [19:0] wdata;

	assign we    = !clr_done_q || (adv && v_s1 && use_sm);
	assign waddr = clr_done_q ? ADDR_W'(bin_s1) : clr_q;
	assign wdata = clr_done_q ? blend_w : AVG_RESET;

	always_ff @(posedge clk) begin
		if (we) begin
			avg_mem[waddr] <= wdata;
		end
		if (adv) begin
			rd_q <= avg_mem[ADDR_W'(in_bin)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s1 <= in_bin;
			pwr_s1 <= in_pwr;
			inr_s1 <= ({22'b0, in_bin} < 32'(BIN_COUNT));
			// the item leaving stage 1 writes this bin at the same edge: bypass
			fwd_s1 <= v_s1 && use_sm && (bin_s1 == in_bin);
		end
	end

	// Stage 2: level
	logic               v_s2;
	logic [9:0]         bin_s2;
	logic signed [20:0] lvl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s2 <= bin_s1;
			lvl_s2 <= lvl_w;
			avg_s2 <= blend_w;
		end
	end

	// Stage 3: clamp to display window
	logic signed [20:0] f21;
	logic signed [20:0] c21;
	logic signed [20:0] x_w;
	logic signed [20:0] dx_w;
	logic signed [20:0] span_w;

	assign f21    = {{4{floor_q[16]}}, floor_q};
	assign c21    = {{5{ceil_q[15]}}, ceil_q};
	assign x_w    = (lvl_s2 < f21) ? f21 : ((lvl_s2 > c21) ? c21 : lvl_s2);
	assign dx_w   = x_w - f21;
	assign span_w = c21 - f21;

	logic               v_s3;
	logic [9:0]         bin_s3;
	logic signed [20:0] lvl_s3;
	logic [16:0]        dx_s3;
	logic [16:0]        span_s3;
	logic               emp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s3  <= bin_s2;
			lvl_s3  <= lvl_s2;
			dx_s3   <= dx_w[16:0];
			span_s3 <= span_w[16:0];
			emp_s3  <= !(c21 > f21);
		end
	end

	// Stage 4: numerator
	logic               v_s4;
	logic [9:0]         bin_s4;
	logic signed [20:0] lvl_s4;
	logic [36:0]        num_s4;
	logic [16:0]        span_s4;
	logic               emp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s4  <= bin_s3;
			lvl_s4  <= lvl_s3;
			num_s4  <= 37'(dx_s3) * 37'(ID_SCALE);
			span_s4 <= span_s3;
			emp_s4  <= emp_s3;
		end
	end

	// Divider stages: one quotient bit each, most significant first
	logic               div_v_sd    [DIV_STEPS];
	logic [9:0]         div_bin_sd  [DIV_STEPS];
	logic signed [20:0] div_lvl_sd  [DIV_STEPS];
	logic [36:0]        div_rem_sd  [DIV_STEPS];
	logic [19:0]        div_q_sd    [DIV_STEPS];
	logic [16:0]        div_span_sd [DIV_STEPS];
	logic               div_emp_sd  [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic               v_in;
		logic [9:0]         bin_in;
		logic signed [20:0] lvl_in;
		logic [36:0]        rem_in;
		logic [19:0]        q_in;
		logic [16:0]        span_in;
		logic               emp_in;
		logic [36:0]        dvs;
		logic               ge;

		if (k == 0) begin : g_first
			assign v_in    = v_s4;
			assign bin_in  = bin_s4;
			assign lvl_in  = lvl_s4;
			assign rem_in  = num_s4;
			assign q_in    = '0;
			assign span_in = span_s4;
			assign emp_in  = emp_s4;
		end else begin : g_next
			assign v_in    = div_v_sd[k-1];
			assign bin_in  = div_bin_sd[k-1];
			assign lvl_in  = div_lvl_sd[k-1];
			assign rem_in  = div_rem_sd[k-1];
			assign q_in    = div_q_sd[k-1];
			assign span_in = div_span_sd[k-1];
			assign emp_in  = div_emp_sd[k-1];
		end

		assign dvs = 37'(span_in) << (DIV_STEPS - 1 - k);
		assign ge  = (rem_in >= dvs);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_sd[k] <= 1'b0;
			end else if (adv) begin
				div_v_sd[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_bin_sd[k]  <= bin_in;
				div_lvl_sd[k]  <= lvl_in;
				div_rem_sd[k]  <= ge ? (rem_in - dvs) : rem_in;
				div_q_sd[k]    <= q_in | (20'(ge) << (DIV_STEPS - 1 - k));
				div_span_sd[k] <= span_in;
				div_emp_sd[k]  <= emp_in;
			end
		end
	end

	// Stage 5: scale the index by the colour count
	logic               v_s5;
	logic [9:0]         bin_s5;
	logic signed [20:0] lvl_s5;
	logic [23:0]        t_s5;
	logic               emp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= div_v_sd[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s5 <= div_bin_sd[DIV_STEPS-1];
			lvl_s5 <= div_lvl_sd[DIV_STEPS-1];
			t_s5   <= 24'(div_q_sd[DIV_STEPS-1]) * 24'(COLOUR_MUL);
			emp_s5 <= div_emp_sd[DIV_STEPS-1];
		end
	end

	// Stage 6: colour number and fraction, t below 13 * 10^6
	logic [23:0] tr_w;
	logic [3:0]  lo_w;

	always_comb begin
		tr_w = t_s5;
		lo_w = '0;
		for (int k = 3; k >= 0; k--) begin
			if (tr_w >= (MAP_STEPS << k)) begin
				tr_w    = tr_w - (MAP_STEPS << k);
				lo_w[k] = 1'b1;
			end
		end
	end

	logic               v_s6;
	logic [9:0]         bin_s6;
	logic signed [20:0] lvl_s6;
	logic [3:0]         lo_s6;
	logic [19:0]        rem_s6;
	logic               emp_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s6 <= bin_s5;
			lvl_s6 <= lvl_s5;
			lo_s6  <= emp_s5 ? 4'd0 : lo_w;
			rem_s6 <= emp_s5 ? 20'd0 : tr_w[19:0];
			emp_s6 <= emp_s5;
		end
	end

	// Stage 7: offset blend term per component, u = (hi - lo) * rem + 255 * 10^6
	logic [3:0]  hi_w;
	rgb_t        clo_w;
	rgb_t        chi_w;
	logic [28:0] u_w [3];

	assign hi_w  = (lo_s6 >= COLOUR_LAST) ? COLOUR_LAST : (lo_s6 + 4'(rem_s6 != 20'd0));
	assign clo_w = colour_rgb(lo_s6);
	assign chi_w = colour_rgb(hi_w);

	always_comb begin
		logic signed [8:0]  d;
		logic signed [29:0] p;
		for (int c = 0; c < 3; c++) begin
			d      = $signed({1'b0, chi_w[8*c +: 8]}) - $signed({1'b0, clo_w[8*c +: 8]});
			p      = 30'(d) * 30'($signed({1'b0, rem_s6})) + U_OFFSET;
			u_w[c] = p[28:0];
		end
	end

	logic               v_s7;
	logic [9:0]         bin_s7;
	logic signed [20:0] lvl_s7;
	rgb_t               clo_s7;
	logic [28:0]        u_s7 [3];
	logic               emp_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s7 <= bin_s6;
			lvl_s7 <= lvl_s6;
			clo_s7 <= clo_w;
			u_s7   <= u_w;
			emp_s7 <= emp_s6;
		end
	end

	// Stage 8: quotient estimate by reciprocal, exact or one too high
	logic               v_s8;
	logic [9:0]         bin_s8;
	logic signed [20:0] lvl_s8;
	rgb_t               clo_s8;
	logic [28:0]        u_s8  [3];
	logic [9:0]         q0_s8 [3];
	logic               emp_s8;
	logic [49:0]        qp_w  [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qp_w[c] = 50'(u_s7[c]) * 50'(RECIP_M);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s8 <= bin_s7;
			lvl_s8 <= lvl_s7;
			clo_s8 <= clo_s7;
			u_s8   <= u_s7;
			for (int c = 0; c < 3; c++) begin
				q0_s8[c] <= qp_w[c][49:40];
			end
			emp_s8 <= emp_s7;
		end
	end

	// Stage 9: correct the estimate, drop the offset, hold for the sink
	logic [7:0] comp_w [3];

	always_comb begin
		logic [29:0] back;
		logic [9:0]  q;
		logic [10:0] s;
		for (int c = 0; c < 3; c++) begin
			back      = 30'(q0_s8[c]) * MAP_STEPS_W;
			q         = (back > 30'(u_s8[c])) ? (q0_s8[c] - 10'd1) : q0_s8[c];
			s         = 11'(clo_s8[8*c +: 8]) + 11'(q) - 11'd255;
			comp_w[c] = s[7:0];
		end
	end

	logic [9:0]  bin_s9;
	logic [18:0] lvl_s9;
	logic [7:0]  red_s9;
	logic [7:0]  green_s9;
	logic [7:0]  blue_s9;
	logic        emp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s9   <= bin_s8;
			lvl_s9   <= lvl_s8[18:0];
			blue_s9  <= comp_w[0];
			green_s9 <= comp_w[1];
			red_s9   <= comp_w[2];
			emp_s9   <= emp_s8;
		end
	end

	assign m_tvalid = v_s9;
	assign m_tdata  = {3'b000, blue_s9, green_s9, red_s9, lvl_s9, bin_s9};

	`SSC_CHECK_NOW(a_no_take_in_clear, s_tvalid && s_tready, clr_done_q,
		"item taken while the average store is being cleared")
	`SSC_CHECK_NOW(a_empty_in_clear, !clr_done_q, !v_s1 && !v_s2 && !m_tvalid,
		"pipeline busy during the store clear")
	`SSC_CHECK_NOW(a_empty_window, m_tvalid && emp_s9,
		{red_s9, green_s9, blue_s9} == COLOUR_ZERO,
		"empty display window did not give colour zero")

endmodule
